[design/tqla_pkg.sv]
// Shared types and constants of the tabular Q-learning agent.
// Used by the controller, the datapath and the top level; no dependencies.
package tqla_pkg;

    localparam int VAL_W = 48;
    localparam int CNT_W = 32;
    localparam int REW_W = 32;

    // Iterative divider: unsigned dividend and divisor widths.
    localparam int DIV_NW = 57;
    localparam int DIV_DW = 33;

    localparam logic [1:0] MODE_CHOOSE = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;

    localparam logic [2:0] CFG_PLAYER  = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_COLS    = 3'd2;
    localparam logic [2:0] CFG_DISC    = 3'd3;
    localparam logic [2:0] CFG_OPT     = 3'd4;
    localparam logic [2:0] CFG_WARMUP  = 3'd5;

    // Datapath operations issued by the controller.
    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_LOAD       = 5'd1;
    localparam logic [4:0] OP_EXPL_MUL   = 5'd2;
    localparam logic [4:0] OP_DIV_MOD    = 5'd3;
    localparam logic [4:0] OP_RES_EXPL   = 5'd4;
    localparam logic [4:0] OP_SCAN_RD    = 5'd5;
    localparam logic [4:0] OP_SCAN_CMP   = 5'd6;
    localparam logic [4:0] OP_RES_GREEDY = 5'd7;
    localparam logic [4:0] OP_PREP       = 5'd8;
    localparam logic [4:0] OP_MOD        = 5'd9;
    localparam logic [4:0] OP_DIV_FILL   = 5'd10;
    localparam logic [4:0] OP_FILL_SET   = 5'd11;
    localparam logic [4:0] OP_SWEEP_FILL = 5'd12;
    localparam logic [4:0] OP_SWEEP_CLR  = 5'd13;
    localparam logic [4:0] OP_RD_Q       = 5'd14;
    localparam logic [4:0] OP_MUL_LO     = 5'd15;
    localparam logic [4:0] OP_MUL_HI     = 5'd16;
    localparam logic [4:0] OP_DISC       = 5'd17;
    localparam logic [4:0] OP_DIFF       = 5'd18;
    localparam logic [4:0] OP_DIV_UPD    = 5'd19;
    localparam logic [4:0] OP_UPD_FIN    = 5'd20;
    localparam logic [4:0] OP_WR2        = 5'd21;
    localparam logic [4:0] OP_RES_ZERO   = 5'd22;

    typedef struct packed {
        logic [4:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       explore;
        logic       fill_needed;
        logic       last_valid;
        logic       scan_last;
        logic       sweep_last;
        logic       div_done;
    } status_t;

endpackage

[design/tqla_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tqla_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/tqla_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tqla_pkg for the operand widths.
module tqla_div
    import tqla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder,
    output logic              done
);

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(DIV_NW - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(shifted - {1'b0, den_reg}) : shifted[DIV_DW-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

[design/tqla_ctrl.sv]
// Sequencer of the Q-learning agent: walks each transaction through its steps.
// Depends on tqla_pkg for the command and status structs.
module tqla_ctrl
    import tqla_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    localparam logic [4:0] ST_CLEAR      = 5'd0;
    localparam logic [4:0] ST_IDLE       = 5'd1;
    localparam logic [4:0] ST_DECODE     = 5'd2;
    localparam logic [4:0] ST_M0_MUL     = 5'd3;
    localparam logic [4:0] ST_M0_TEST    = 5'd4;
    localparam logic [4:0] ST_M0_DIVW    = 5'd5;
    localparam logic [4:0] ST_M0_RES_E   = 5'd6;
    localparam logic [4:0] ST_SCAN_RD    = 5'd7;
    localparam logic [4:0] ST_SCAN_CMP   = 5'd8;
    localparam logic [4:0] ST_M0_RES_G   = 5'd9;
    localparam logic [4:0] ST_M1_PREP    = 5'd10;
    localparam logic [4:0] ST_M1_MOD     = 5'd11;
    localparam logic [4:0] ST_FILL_START = 5'd12;
    localparam logic [4:0] ST_FILL_DIVW  = 5'd13;
    localparam logic [4:0] ST_FILL_SET   = 5'd14;
    localparam logic [4:0] ST_FILL_SWEEP = 5'd15;
    localparam logic [4:0] ST_RD_Q       = 5'd16;
    localparam logic [4:0] ST_MUL_LO     = 5'd17;
    localparam logic [4:0] ST_MUL_HI     = 5'd18;
    localparam logic [4:0] ST_DISC       = 5'd19;
    localparam logic [4:0] ST_DIFF       = 5'd20;
    localparam logic [4:0] ST_UPD_START  = 5'd21;
    localparam logic [4:0] ST_UPD_DIVW   = 5'd22;
    localparam logic [4:0] ST_UPD_FIN    = 5'd23;
    localparam logic [4:0] ST_M2         = 5'd24;
    localparam logic [4:0] ST_M3         = 5'd25;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [4:0] after_fill;

    assign after_fill = status.last_valid ? ST_SCAN_RD : ST_UPD_FIN;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_SWEEP_CLR;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.mode)
                    MODE_CHOOSE: state_next = ST_M0_MUL;
                    MODE_UPDATE: state_next = ST_M1_PREP;
                    MODE_WRITE:  state_next = ST_M2;
                    default:     state_next = ST_M3;
                endcase
            end
            ST_M0_MUL:
            begin
                cmd.op     = OP_EXPL_MUL;
                state_next = ST_M0_TEST;
            end
            ST_M0_TEST:
            begin
                if (status.explore)
                begin
                    cmd.op     = OP_DIV_MOD;
                    state_next = ST_M0_DIVW;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_M0_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_M0_RES_E;
                end
            end
            ST_M0_RES_E:
            begin
                cmd.op     = OP_RES_EXPL;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                cmd.op     = OP_SCAN_RD;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.op = OP_SCAN_CMP;
                if (!status.scan_last)
                begin
                    state_next = ST_SCAN_RD;
                end
                else if (status.mode == MODE_CHOOSE)
                begin
                    state_next = ST_M0_RES_G;
                end
                else
                begin
                    state_next = ST_RD_Q;
                end
            end
            ST_M0_RES_G:
            begin
                cmd.op     = OP_RES_GREEDY;
                state_next = ST_IDLE;
            end
            ST_M1_PREP:
            begin
                cmd.op     = OP_PREP;
                state_next = ST_M1_MOD;
            end
            ST_M1_MOD:
            begin
                cmd.op     = OP_MOD;
                state_next = status.fill_needed ? ST_FILL_START : after_fill;
            end
            ST_FILL_START:
            begin
                cmd.op     = OP_DIV_FILL;
                state_next = ST_FILL_DIVW;
            end
            ST_FILL_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FILL_SET;
                end
            end
            ST_FILL_SET:
            begin
                cmd.op     = OP_FILL_SET;
                state_next = ST_FILL_SWEEP;
            end
            ST_FILL_SWEEP:
            begin
                cmd.op = OP_SWEEP_FILL;
                if (status.sweep_last)
                begin
                    state_next = after_fill;
                end
            end
            ST_RD_Q:
            begin
                cmd.op     = OP_RD_Q;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_DISC;
            end
            ST_DISC:
            begin
                cmd.op     = OP_DISC;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = ST_UPD_START;
            end
            ST_UPD_START:
            begin
                cmd.op     = OP_DIV_UPD;
                state_next = ST_UPD_DIVW;
            end
            ST_UPD_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPD_FIN;
                end
            end
            ST_UPD_FIN:
            begin
                cmd.op     = OP_UPD_FIN;
                state_next = ST_IDLE;
            end
            ST_M2:
            begin
                cmd.op     = OP_WR2;
                state_next = ST_IDLE;
            end
            ST_M3:
            begin
                cmd.op     = OP_RES_ZERO;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[design/tqla_dp.sv]
// Datapath of the Q-learning agent: config, learner state, value and count
// memories, multipliers and the shared divider. Depends on tqla_pkg,
// tqla_ram and tqla_div.
module tqla_dp
    import tqla_pkg::*;
#(
    parameter int MAX_ACTIONS = 16,
    parameter int MAX_STATES  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        mode,
    input  logic [3:0]        action_row,
    input  logic [3:0]        action_col,
    input  logic signed [31:0] reward,
    input  logic [15:0]       explore_draw,
    input  logic [7:0]        random_action,
    input  logic [15:0]       tie_bits,
    input  logic signed [47:0] init_value,
    input  logic [7:0]        init_state,
    input  logic [3:0]        init_action,
    output logic              done,
    output logic [3:0]        chosen_action,
    output logic              explored,
    output logic signed [47:0] value_written
);

    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(MAX_STATES);
    localparam int LIM   = (MAX_ACTIONS < 16) ? MAX_ACTIONS : 16;
    localparam int RECIP = 65536 / MAX_STATES;

    // configuration
    logic        player_reg;
    logic [4:0]  rows_cfg_reg;
    logic [4:0]  cols_cfg_reg;
    logic [15:0] disc_reg;
    logic        opt_reg;
    logic [4:0]  warm_reg;

    // latched transaction
    logic [1:0]  mode_reg;
    logic [3:0]  ar_reg;
    logic [3:0]  ac_reg;
    logic [31:0] reward_reg;
    logic [15:0] draw_reg;
    logic [7:0]  rand_reg;
    logic [15:0] tie_reg;
    logic [47:0] initv_reg;
    logic [7:0]  inits_reg;
    logic [3:0]  inita_reg;

    // learner state
    logic [SW-1:0] lastm_reg;
    logic          last_valid_reg;
    logic [31:0]   step_reg;
    logic [31:0]   best_reg;

    // working registers
    logic [7:0]         next_reg;
    logic [SW-1:0]      nextm_reg;
    logic [3:0]         mine_reg;
    logic [48:0]        prod_reg;
    logic [3:0]         idx_reg;
    logic signed [47:0] best_q_reg;
    logic [3:0]         best_a_reg;
    logic [AW-1:0]      sw_addr_reg;
    logic signed [47:0] fill_reg;
    logic signed [47:0] q_reg;
    logic [31:0]        cnt_reg;
    logic [39:0]        plo_reg;
    logic signed [40:0] phi_reg;
    logic signed [47:0] dq_reg;
    logic signed [49:0] diff_reg;

    // result
    logic               done_reg;
    logic [3:0]         act_reg;
    logic               expl_reg;
    logic signed [47:0] val_reg;

    function automatic logic [4:0] clamp_cnt(input logic [4:0] c);
        if (c == 5'd0)
        begin
            return 5'd1;
        end
        else if (c > 5'(LIM))
        begin
            return 5'(LIM);
        end
        return c;
    endfunction

    // state index mod MAX_STATES by reciprocal and one correction
    function automatic logic [SW-1:0] state_mod(input logic [7:0] s);
        logic [23:0] p;
        logic [23:0] r;
        p = 24'(s) * 24'(RECIP);
        r = 24'(s) - 24'(p[23:16]) * 24'(MAX_STATES);
        if (r >= 24'(MAX_STATES))
        begin
            r = r - 24'(MAX_STATES);
        end
        return r[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] st, input logic [3:0] a);
        return AW'(st) * AW'(MAX_ACTIONS) + AW'(a);
    endfunction

    logic [4:0] rows_cnt;
    logic [4:0] cols_cnt;
    logic [4:0] n_cnt;

    assign rows_cnt = clamp_cnt(rows_cfg_reg);
    assign cols_cnt = clamp_cnt(cols_cfg_reg);
    assign n_cnt    = player_reg ? cols_cnt : rows_cnt;

    // memories
    logic          q_we;
    logic          c_we;
    logic [AW-1:0] waddr;
    logic [47:0]   q_wdata;
    logic [31:0]   c_wdata;
    logic [AW-1:0] raddr;
    logic [47:0]   q_rdata;
    logic [31:0]   c_rdata;

    tqla_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_qram (
        .clk   (clk),
        .we    (q_we),
        .waddr (waddr),
        .wdata (q_wdata),
        .raddr (raddr),
        .rdata (q_rdata)
    );

    tqla_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cram (
        .clk   (clk),
        .we    (c_we),
        .waddr (waddr),
        .wdata (c_wdata),
        .raddr (raddr),
        .rdata (c_rdata)
    );

    // divider
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic              div_done;

    tqla_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // combinational helpers
    logic [SW-1:0]      scan_row;
    logic [47:0]        fill_num;
    logic [47:0]        fill_mag;
    logic [47:0]        fill_val;
    logic [49:0]        diff_mag;
    logic signed [48:0] delta;
    logic signed [48:0] sum_q;
    logic signed [47:0] new_q;
    logic [31:0]        cnt_inc;
    logic               wr2_ok;
    logic signed [63:0] prod64;
    logic signed [63:0] prod_sh;
    logic [3:0]         rows_m1;
    logic [3:0]         cols_m1;
    logic [3:0]         ar_c;
    logic [3:0]         ac_c;
    logic [8:0]         next9;

    assign scan_row = (mode_reg == MODE_CHOOSE) ? lastm_reg : nextm_reg;
    assign fill_num = {best_reg, 16'h0000};
    assign fill_mag = best_reg[31] ? (48'd0 - fill_num) : fill_num;
    assign fill_val = best_reg[31] ? (48'd0 - div_quo[47:0]) : div_quo[47:0];
    assign diff_mag = diff_reg[49] ? (50'd0 - diff_reg) : diff_reg;
    assign delta    = diff_reg[49] ? (49'sd0 - $signed({1'b0, div_quo[47:0]}))
                                   : $signed({1'b0, div_quo[47:0]});
    assign sum_q    = $signed({q_reg[47], q_reg}) + delta;
    assign new_q    = (sum_q[48] != sum_q[47])
                      ? (sum_q[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                      : sum_q[47:0];
    assign cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 32'd1;
    assign wr2_ok   = (int'(inits_reg) < MAX_STATES) && (int'(inita_reg) < MAX_ACTIONS);
    // high partial product fits 40 signed bits (17 x 24 with a 16-bit magnitude)
    assign prod64   = $signed({phi_reg[39:0], 24'd0}) + $signed({24'd0, plo_reg});
    assign prod_sh  = prod64 >>> 16;
    assign rows_m1  = 4'(rows_cnt - 5'd1);
    assign cols_m1  = 4'(cols_cnt - 5'd1);
    assign ar_c     = (ar_reg > rows_m1) ? rows_m1 : ar_reg;
    assign ac_c     = (ac_reg > cols_m1) ? cols_m1 : ac_reg;
    assign next9    = 9'(ac_c) * 9'(rows_cnt) + 9'(ar_c);

    always_comb
    begin
        q_we      = 1'b0;
        c_we      = 1'b0;
        waddr     = addr_of(lastm_reg, mine_reg);
        q_wdata   = new_q;
        c_wdata   = cnt_inc;
        raddr     = addr_of(scan_row, idx_reg);
        div_start = 1'b0;
        div_num   = (DIV_NW'(diff_mag) << 6) + (DIV_NW'(diff_mag) << 5)
                    + (DIV_NW'(diff_mag) << 2);
        div_den   = DIV_DW'(cnt_reg) + DIV_DW'(1000);
        unique case (cmd.op)
            OP_SWEEP_CLR:
            begin
                c_we    = 1'b1;
                waddr   = sw_addr_reg;
                c_wdata = '0;
            end
            OP_SWEEP_FILL:
            begin
                q_we    = 1'b1;
                c_we    = 1'b1;
                waddr   = sw_addr_reg;
                q_wdata = fill_reg;
                c_wdata = '0;
            end
            OP_RD_Q:
            begin
                raddr = addr_of(lastm_reg, mine_reg);
            end
            OP_UPD_FIN:
            begin
                q_we = last_valid_reg;
                c_we = last_valid_reg;
            end
            OP_WR2:
            begin
                q_we    = wr2_ok;
                waddr   = addr_of(SW'(inits_reg), inita_reg);
                q_wdata = initv_reg;
            end
            OP_DIV_MOD:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(rand_reg);
                div_den   = DIV_DW'(n_cnt);
            end
            OP_DIV_FILL:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(fill_mag);
                div_den   = DIV_DW'(17'h10000 - {1'b0, disc_reg});
            end
            OP_DIV_UPD:
            begin
                div_start = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // configuration and learner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_reg     <= 1'b0;
            rows_cfg_reg   <= 5'd2;
            cols_cfg_reg   <= 5'd2;
            disc_reg       <= 16'd62259;
            opt_reg        <= 1'b0;
            warm_reg       <= 5'd15;
            lastm_reg      <= '0;
            last_valid_reg <= 1'b0;
            step_reg       <= '0;
            best_reg       <= 32'h8000_0000;
            sw_addr_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PLAYER: player_reg   <= cfg_data[0];
                    CFG_ROWS:   rows_cfg_reg <= cfg_data[4:0];
                    CFG_COLS:   cols_cfg_reg <= cfg_data[4:0];
                    CFG_DISC:   disc_reg     <= cfg_data;
                    CFG_OPT:    opt_reg      <= cfg_data[0];
                    CFG_WARMUP: warm_reg     <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
            unique case (cmd.op)
                OP_PREP:
                begin
                    if ($signed(reward_reg) > $signed(best_reg))
                    begin
                        best_reg <= reward_reg;
                    end
                end
                OP_SWEEP_CLR, OP_SWEEP_FILL:
                begin
                    sw_addr_reg <= (sw_addr_reg == AW'(DEPTH - 1)) ? '0 : sw_addr_reg + 1'b1;
                end
                OP_UPD_FIN:
                begin
                    lastm_reg      <= nextm_reg;
                    last_valid_reg <= 1'b1;
                    if (step_reg != '1)
                    begin
                        step_reg <= step_reg + 32'd1;
                    end
                    done_reg <= 1'b1;
                end
                OP_RES_EXPL, OP_RES_GREEDY, OP_WR2, OP_RES_ZERO:
                begin
                    done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                mode_reg   <= mode;
                ar_reg     <= action_row;
                ac_reg     <= action_col;
                reward_reg <= reward;
                draw_reg   <= explore_draw;
                rand_reg   <= random_action;
                tie_reg    <= tie_bits;
                initv_reg  <= init_value;
                inits_reg  <= init_state;
                inita_reg  <= init_action;
                idx_reg    <= '0;
            end
            OP_EXPL_MUL:
            begin
                prod_reg <= 49'(draw_reg) * (49'(step_reg) + 49'd100);
            end
            OP_SCAN_CMP:
            begin
                if (idx_reg == '0 || $signed(q_rdata) > best_q_reg
                    || ($signed(q_rdata) == best_q_reg && tie_reg[idx_reg]))
                begin
                    best_q_reg <= q_rdata;
                    best_a_reg <= idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            OP_PREP:
            begin
                next_reg <= next9[7:0];
                mine_reg <= player_reg ? ac_c : ar_c;
            end
            OP_MOD:
            begin
                nextm_reg <= state_mod(next_reg);
            end
            OP_FILL_SET:
            begin
                fill_reg <= fill_val;
            end
            OP_MUL_LO:
            begin
                q_reg   <= q_rdata;
                cnt_reg <= c_rdata;
                plo_reg <= 40'(disc_reg) * 40'(best_q_reg[23:0]);
            end
            OP_MUL_HI:
            begin
                phi_reg <= $signed({1'b0, disc_reg}) * $signed(best_q_reg[47:24]);
            end
            OP_DISC:
            begin
                // toward zero: bump the floored shift when negative and inexact
                dq_reg <= prod_sh[47:0]
                          + ((prod64[63] && prod64[15:0] != 16'd0) ? 48'sd1 : 48'sd0);
            end
            OP_DIFF:
            begin
                diff_reg <= $signed({{18{reward_reg[31]}}, reward_reg})
                            + $signed({{2{dq_reg[47]}}, dq_reg})
                            - $signed({{2{q_reg[47]}}, q_reg});
            end
            OP_RES_EXPL:
            begin
                act_reg  <= div_rem[3:0];
                expl_reg <= 1'b1;
                val_reg  <= '0;
            end
            OP_RES_GREEDY:
            begin
                act_reg  <= best_a_reg;
                expl_reg <= 1'b0;
                val_reg  <= '0;
            end
            OP_UPD_FIN:
            begin
                act_reg  <= '0;
                expl_reg <= 1'b0;
                val_reg  <= last_valid_reg ? new_q : 48'sd0;
            end
            OP_WR2:
            begin
                act_reg  <= '0;
                expl_reg <= 1'b0;
                val_reg  <= wr2_ok ? initv_reg : 48'sd0;
            end
            OP_RES_ZERO:
            begin
                act_reg  <= '0;
                expl_reg <= 1'b0;
                val_reg  <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign status.mode        = mode_reg;
    assign status.explore     = (prod_reg < 49'd655350) || !last_valid_reg
                                || (opt_reg && (step_reg < 32'(warm_reg)));
    assign status.fill_needed = opt_reg && (step_reg == 32'(warm_reg));
    assign status.last_valid  = last_valid_reg;
    assign status.scan_last   = ({1'b0, idx_reg} == (n_cnt - 5'd1));
    assign status.sweep_last  = (sw_addr_reg == AW'(DEPTH - 1));
    assign status.div_done    = div_done;

    assign done          = done_reg;
    assign chosen_action = act_reg;
    assign explored      = expl_reg;
    assign value_written = val_reg;

endmodule

[design/tabular_q_learning_agent.sv]
// Top level of the tabular Q-learning agent for a two-player matrix game.
// Depends on tqla_pkg, tqla_ctrl and tqla_dp (which holds tqla_ram, tqla_div).
//
// One transaction at a time: a command is taken when start is high and busy
// is low; its single result appears on chosen_action/explored/value_written
// for exactly one cycle with done high, and must be captured then since
// there is no way to stall it. A new command may be issued in the same cycle
// that done is shown. After reset, busy stays high while the visit-count
// memory is cleared; configuration writes are taken during that time.
// The sequencer, the bit-serial divider (57 quotient bits, one per cycle)
// and the one-read-port value memory serve the commands as follows:
//   choose, exploring : divider for random_action mod n
//   choose, greedy    : one table read and compare per action
//   update            : the same scan of the next state and a division when
//                       there is a previous state; the update that ends the
//                       optimistic warm-up adds the fill division and the
//                       table refill
//   write entry       : one table write if in range; unused mode: zero result
// Values are signed Q32.16 in the table, Q16.16 rewards; all results
// saturate to 48 bits and divisions round toward zero.
module tabular_q_learning_agent
    import tqla_pkg::*;
#(
    parameter int MAX_ACTIONS = 16,
    parameter int MAX_STATES  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         mode,
    input  logic [3:0]         action_row,
    input  logic [3:0]         action_col,
    input  logic signed [31:0] reward,
    input  logic [15:0]        explore_draw,
    input  logic [7:0]         random_action,
    input  logic [15:0]        tie_bits,
    input  logic signed [47:0] init_value,
    input  logic [7:0]         init_state,
    input  logic [3:0]         init_action,
    output logic               done,
    output logic [3:0]         chosen_action,
    output logic               explored,
    output logic signed [47:0] value_written
);

    cmd_t    cmd;
    status_t status;

    // sequencer: one state per step of a transaction
    tqla_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // registers, memories, multipliers and divider
    tqla_dp #(
        .MAX_ACTIONS (MAX_ACTIONS),
        .MAX_STATES  (MAX_STATES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .action_row    (action_row),
        .action_col    (action_col),
        .reward        (reward),
        .explore_draw  (explore_draw),
        .random_action (random_action),
        .tie_bits      (tie_bits),
        .init_value    (init_value),
        .init_state    (init_state),
        .init_action   (init_action),
        .done          (done),
        .chosen_action (chosen_action),
        .explored      (explored),
        .value_written (value_written)
    );

endmodule

[bench/tb.sv]
// Self-checking bench for tabular_q_learning_agent: a directed table, then random traffic.
// Depends on tqla_pkg and the agent RTL; the expected results come from a predictor kept here.
`timescale 1ns / 100ps

module tb;
    import tqla_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         NUM_STATES  = 256;
    localparam int         NUM_ACTS    = 16;
    localparam int         TBL_SIZE    = NUM_STATES * NUM_ACTS;
    localparam int         PHASE_ITEMS = 260;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam longint     V48_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     V48_MIN     = -64'sh0000_8000_0000_0000;

    // One command transaction as presented on the input ports.
    typedef struct {
        logic [1:0]         mode;
        logic [3:0]         ar;
        logic [3:0]         ac;
        logic signed [31:0] rew;
        logic [15:0]        draw;
        logic [7:0]         ra;
        logic [15:0]        tie;
        logic signed [47:0] iv;
        logic [7:0]         ist;
        logic [3:0]         ia;
    } agent_cmd_t;

    typedef struct {
        logic [3:0]  act;
        logic        expl;
        logic [47:0] val;
    } agent_res_t;

    // Directed row: a command plus, optionally, a result typed in by hand.
    typedef struct {
        agent_cmd_t cmd;
        bit         has_lit;
        agent_res_t lit;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic [1:0]         mode;
    logic [3:0]         action_row;
    logic [3:0]         action_col;
    logic signed [31:0] reward;
    logic [15:0]        explore_draw;
    logic [7:0]         random_action;
    logic [15:0]        tie_bits;
    logic signed [47:0] init_value;
    logic [7:0]         init_state;
    logic [3:0]         init_action;
    logic               done;
    logic [3:0]         chosen_action;
    logic               explored;
    logic signed [47:0] value_written;

    tabular_q_learning_agent u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .action_row    (action_row),
        .action_col    (action_col),
        .reward        (reward),
        .explore_draw  (explore_draw),
        .random_action (random_action),
        .tie_bits      (tie_bits),
        .init_value    (init_value),
        .init_state    (init_state),
        .init_action   (init_action),
        .done          (done),
        .chosen_action (chosen_action),
        .explored      (explored),
        .value_written (value_written)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the agent's registers and memories
    // ------------------------------------------------------------------
    bit          pl_idx;
    int unsigned rows_reg;
    int unsigned cols_reg;
    longint      gamma_reg;
    bit          opt_reg;
    int unsigned warm_reg;
    longint      q_tbl [TBL_SIZE];
    int unsigned visits [TBL_SIZE];
    int unsigned prev_state;
    bit          prev_valid;
    int unsigned steps;
    longint      best_rew;

    agent_res_t  pending_results[$];
    int          errors;
    int          cycles;
    int          burst_left;

    function automatic int unsigned clamp_cnt(int unsigned c);
        if (c < 1) return 1;
        if (c > NUM_ACTS) return NUM_ACTS;
        return c;
    endfunction

    function automatic longint sat48(longint v);
        if (v > V48_MAX) return V48_MAX;
        if (v < V48_MIN) return V48_MIN;
        return v;
    endfunction

    // Computes the result of one accepted transaction and advances the state.
    function automatic agent_res_t predict_agent(agent_cmd_t c);
        agent_res_t  r;
        int unsigned n;
        int unsigned nr;
        int unsigned nc;
        int unsigned ar;
        int unsigned ac;
        int unsigned nxt;
        int unsigned mine;
        int unsigned ix;
        longint      best;
        longint      q;
        longint      rw;
        longint      tgt;
        longint      fill;
        bit          go_random;

        r = '{act: 4'd0, expl: 1'b0, val: 48'd0};
        n = clamp_cnt(pl_idx ? cols_reg : rows_reg);
        case (c.mode)
            MODE_CHOOSE: begin
                go_random = (longint'(c.draw) * (100 + longint'(steps)) < 655350)
                            || !prev_valid || (opt_reg && steps < warm_reg);
                if (go_random) begin
                    r.act  = 4'(int'(c.ra) % n);
                    r.expl = 1'b1;
                end else begin
                    best = q_tbl[prev_state * NUM_ACTS];
                    for (int i = 1; i < n; i++) begin
                        q = q_tbl[prev_state * NUM_ACTS + i];
                        if (q > best || (q == best && c.tie[i])) begin
                            best  = q;
                            r.act = 4'(i);
                        end
                    end
                end
            end
            MODE_UPDATE: begin
                nr = clamp_cnt(rows_reg);
                nc = clamp_cnt(cols_reg);
                ar = (c.ar > nr - 1) ? nr - 1 : c.ar;
                ac = (c.ac > nc - 1) ? nc - 1 : c.ac;
                nxt  = ac * nr + ar;
                mine = pl_idx ? ac : ar;
                if (mine > n - 1) mine = n - 1;
                rw = longint'(c.rew);
                if (rw > best_rew) best_rew = rw;
                // end of warm-up: optimistic refill, visit counts cleared
                if (opt_reg && steps == warm_reg) begin
                    fill = sat48((best_rew * 65536) / (65536 - gamma_reg));
                    for (int k = 0; k < TBL_SIZE; k++) begin
                        q_tbl[k]  = fill;
                        visits[k] = 0;
                    end
                end
                if (prev_valid) begin
                    ix   = prev_state * NUM_ACTS + mine;
                    best = q_tbl[(nxt % NUM_STATES) * NUM_ACTS];
                    for (int i = 1; i < n; i++)
                        if (q_tbl[(nxt % NUM_STATES) * NUM_ACTS + i] > best)
                            best = q_tbl[(nxt % NUM_STATES) * NUM_ACTS + i];
                    tgt = rw + (gamma_reg * best) / 65536;
                    q   = q_tbl[ix];
                    q   = sat48(q + ((tgt - q) * 100) / (1000 + longint'(visits[ix])));
                    q_tbl[ix] = q;
                    if (visits[ix] != 32'hFFFF_FFFF) visits[ix]++;
                    r.val = q[47:0];
                end
                prev_state = nxt & 8'hFF;
                prev_valid = 1'b1;
                if (steps != 32'hFFFF_FFFF) steps++;
            end
            MODE_WRITE: begin
                q_tbl[c.ist * NUM_ACTS + c.ia] = longint'(c.iv);
                r.val = c.iv;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: inputs move on the falling edge, handshakes seen on the rising
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, int unsigned v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = 16'(v);
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            CFG_PLAYER: pl_idx    = v[0];
            CFG_ROWS:   rows_reg  = v & 31;
            CFG_COLS:   cols_reg  = v & 31;
            CFG_DISC:   gamma_reg = v & 16'hFFFF;
            CFG_OPT:    opt_reg   = v[0];
            CFG_WARMUP: warm_reg  = v & 31;
            default: ;
        endcase
    endtask

    // Presents one transaction and returns at the edge that accepts it.
    task automatic send_cmd(agent_cmd_t c, bit has_lit, agent_res_t lit);
        agent_res_t r;
        @(negedge clk);
        start         = 1'b1;
        mode          = c.mode;
        action_row    = c.ar;
        action_col    = c.ac;
        reward        = c.rew;
        explore_draw  = c.draw;
        random_action = c.ra;
        tie_bits      = c.tie;
        init_value    = c.iv;
        init_state    = c.ist;
        init_action   = c.ia;
        do @(posedge clk); while (busy);
        r = predict_agent(c);
        pending_results.push_back(has_lit ? lit : r);
    endtask

    // Bursts of back-to-back commands separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
        gap = $urandom_range(0, 4) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(negedge clk);
        // quiet cycles before the registers change
        repeat (100) @(negedge clk);
    endtask

    function automatic agent_cmd_t blank_cmd(logic [1:0] m);
        agent_cmd_t c;
        c = '{mode: m, ar: 4'd0, ac: 4'd0, rew: 32'sd0, draw: 16'd0, ra: 8'd0,
              tie: 16'd0, iv: 48'sd0, ist: 8'd0, ia: 4'd0};
        return c;
    endfunction

    function automatic agent_cmd_t random_cmd();
        agent_cmd_t c;
        int         pick;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        c.mode = pick < 40 ? MODE_CHOOSE : pick < 85 ? MODE_UPDATE :
                 pick < 96 ? MODE_WRITE : MODE_UNUSED;
        c.ar   = 4'($urandom);
        c.ac   = 4'($urandom);
        w      = $urandom;
        // mostly rewards of a few units, sometimes full scale
        c.rew  = $urandom_range(0, 3) == 0 ? w : {{13{w[18]}}, w[18:0]};
        c.draw = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        c.ra   = 8'($urandom);
        c.tie  = 16'($urandom);
        w      = $urandom;
        c.iv   = $urandom_range(0, 4) == 0 ? {16'($urandom), w}
                                           : {{24{w[23]}}, w[23:0]};
        c.ist  = 8'($urandom);
        c.ia   = 4'($urandom);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every done pulse is matched against the oldest entry
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        agent_res_t e;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result act=%0d expl=%0d val=%h",
                         $time, chosen_action, explored, value_written);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (chosen_action !== e.act) begin
                    $display("%0t: chosen_action expected %0d got %0d",
                             $time, e.act, chosen_action);
                    errors++;
                end
                if (explored !== e.expl) begin
                    $display("%0t: explored expected %0d got %0d", $time, e.expl, explored);
                    errors++;
                end
                if (value_written !== e.val) begin
                    $display("%0t: value_written expected %h got %h",
                             $time, e.val, value_written);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tabular_q_learning_agent test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    dir_row_t   dir_rows[$];
    agent_res_t none;

    // phase settings: player, rows, cols, discount, optimistic, warm-up length
    int unsigned phase_cfg [5][6] = '{
        '{0, 16, 16, 32768, 1, 10},   // optimistic, warm-up already behind
        '{1,  1, 16,     0, 0, 20},
        '{0, 31,  0, 65535, 1, 20},   // counts above 16 and zero clamp
        '{1,  5,  3, 62259, 0, 15},
        '{0,  7, 11,     1, 1, 10}
    };

    task automatic add_row(agent_cmd_t c, bit has_lit, agent_res_t lit);
        dir_row_t d;
        d.cmd = c;
        d.has_lit = has_lit;
        d.lit = lit;
        dir_rows.push_back(d);
    endtask

    initial begin
        agent_cmd_t c;
        logic [31:0] w;

        errors = 0;
        cycles = 0;
        burst_left = 0;
        none = '{act: 4'd0, expl: 1'b0, val: 48'd0};
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PLAYER;
        cfg_data = 16'd0;
        c = blank_cmd(MODE_CHOOSE);
        mode = c.mode;
        action_row = 4'd0;
        action_col = 4'd0;
        reward = 32'sd0;
        explore_draw = 16'd0;
        random_action = 8'd0;
        tie_bits = 16'd0;
        init_value = 48'sd0;
        init_state = 8'd0;
        init_action = 4'd0;

        // predictor reset values
        pl_idx = 1'b0;
        rows_reg = 2;
        cols_reg = 2;
        gamma_reg = 62259;
        opt_reg = 1'b0;
        warm_reg = 15;
        foreach (q_tbl[k]) begin
            q_tbl[k] = 0;
            visits[k] = 0;
        end
        prev_state = 0;
        prev_valid = 1'b0;
        steps = 0;
        best_rew = -64'sd2147483648;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Load the entries the default two-by-two game can reach.
        for (int s = 0; s < 4; s++)
            for (int a = 0; a < 2; a++) begin
                c = blank_cmd(MODE_WRITE);
                w = $urandom;
                c.iv  = {{24{w[23]}}, w[23:0]};
                c.ist = 8'(s);
                c.ia  = 4'(a);
                send_cmd(c, 1'b0, none);
                pace();
            end

        // Directed table, default configuration (two actions each side).
        c = blank_cmd(MODE_CHOOSE);             // no previous state: explores
        c.draw = 16'hFFFF; c.ra = 8'hFF;
        add_row(c, 1'b1, '{act: 4'd1, expl: 1'b1, val: 48'd0});
        c = blank_cmd(MODE_UNUSED);             // unused mode: all zero
        c.ar = 4'hF; c.ac = 4'hF; c.rew = -32'sd1; c.draw = 16'hFFFF; c.ra = 8'hFF;
        c.tie = 16'hFFFF; c.iv = -48'sd1; c.ist = 8'hFF; c.ia = 4'hF;
        add_row(c, 1'b1, none);
        c = blank_cmd(MODE_WRITE);              // largest value, last entry
        c.iv = 48'sh7FFF_FFFF_FFFF; c.ist = 8'hFF; c.ia = 4'hF;
        add_row(c, 1'b1, '{act: 4'd0, expl: 1'b0, val: 48'h7FFF_FFFF_FFFF});
        c = blank_cmd(MODE_WRITE);              // most negative value, entry 0
        c.iv = 48'sh8000_0000_0000;
        add_row(c, 1'b1, '{act: 4'd0, expl: 1'b0, val: 48'h8000_0000_0000});
        c = blank_cmd(MODE_UPDATE);             // first update: nothing to learn yet
        c.ar = 4'hF; c.ac = 4'hF; c.rew = 32'sh7FFF_FFFF;
        add_row(c, 1'b1, none);
        c = blank_cmd(MODE_CHOOSE);             // greedy, no tie preference
        c.draw = 16'hFFFF;
        add_row(c, 1'b0, none);
        c.tie = 16'hFFFF;                       // greedy, ties go to later actions
        add_row(c, 1'b0, none);
        c = blank_cmd(MODE_CHOOSE);             // zero draw always explores
        c.ra = 8'd7;
        add_row(c, 1'b0, none);
        c = blank_cmd(MODE_UPDATE);
        c.rew = 32'sh8000_0000;
        add_row(c, 1'b0, none);
        c = blank_cmd(MODE_WRITE);
        c.ist = 8'd3; c.ia = 4'd1;
        add_row(c, 1'b1, none);
        c = blank_cmd(MODE_UPDATE);
        c.ar = 4'd1; c.ac = 4'd1;
        add_row(c, 1'b0, none);
        c = blank_cmd(MODE_UPDATE);
        c.ar = 4'd1; c.rew = 32'sh0001_0000;
        add_row(c, 1'b0, none);
        c = blank_cmd(MODE_CHOOSE);             // draw near the exploration threshold
        c.draw = 16'd6553; c.tie = 16'h5555;
        add_row(c, 1'b0, none);

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].has_lit, dir_rows[i].lit);
            pace();
        end

        // Warm-up in the two-by-two game until the optimistic fill has
        // written every entry; later phases may read any row.
        wait_idle();
        write_reg(CFG_OPT, 1);
        write_reg(CFG_WARMUP, 10);
        while (steps <= 10) begin
            c = blank_cmd(MODE_UPDATE);
            c.ar = 4'($urandom);
            c.ac = 4'($urandom);
            w = $urandom;
            c.rew = {{13{w[18]}}, w[18:0]};
            send_cmd(c, 1'b0, none);
            pace();
        end

        // Random phases, each under its own register settings.
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), phase_cfg[p][r]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_cmd(random_cmd(), 1'b0, none);
                pace();
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tabular_q_learning_agent test passed");
        else
            $display("tabular_q_learning_agent test failed");
        $finish;
    end

endmodule

[tabular_q_learning_agent.f]
design/tqla_pkg.sv
design/tqla_ram.sv
design/tqla_div.sv
design/tqla_ctrl.sv
design/tqla_dp.sv
design/tabular_q_learning_agent.sv
bench/tb.sv
